### rtl/core/ulat_pkg.sv
// ----------------------------------------------------------------------------
// ulat_pkg
// Shared types and codes of the uart line assembler and transmit ring.
// ----------------------------------------------------------------------------
package ulat_pkg;

	localparam int ULAT_TX_DEPTH = 64;
	localparam int ULAT_LINE_MAX = 32;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// request opcodes
	localparam logic [1:0] OP_RX_BYTE  = 2'd0;
	localparam logic [1:0] OP_TX_READY = 2'd1;
	localparam logic [1:0] OP_TX_BYTE  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_TX_BYTE = 2'd1;
	localparam logic [1:0] KIND_TX_IDLE = 2'd2;
	localparam logic [1:0] KIND_LINE    = 2'd3;

	// push status codes
	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_BAD_LEN  = 2'd1;
	localparam logic [1:0] ST_NO_ROOM  = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       first_of_message;
		logic [7:0] message_length;
	} req_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [1:0] push_status;
		logic [7:0] out_byte;
		logic       last_of_line;
	} res_t;

endpackage

### rtl/core/uart_line_assembler_and_tx_ring.sv
// ----------------------------------------------------------------------------
// uart_line_assembler_and_tx_ring
// Transmit byte ring with whole-message admission and a receive line store
// that is emitted byte by byte on CR or LF.
//
//   channel | signals                    | contents
//   --------+----------------------------+---------------------------------
//   request | req_valid, req_ready, req  | opcode, byte, first flag, length
//   result  | res_valid, res_ready, res  | kind, status, byte, last flag
//
// A request that stores a byte writes its memory as it is taken. A request
// with a single result loads the result register when it is free; a ring pop
// first registers its ring memory read. A line emission gives one stored byte
// per cycle from the line memory read port unless the result side stalls.
// Reset clears control state only; memories need no clearing pass.
// A result register parts the sides: while a result is held, one more
// request with a result is taken, and later requests wait until it drains.
// ----------------------------------------------------------------------------
module uart_line_assembler_and_tx_ring
	import ulat_pkg::*;
#(
	parameter int TX_DEPTH = ULAT_TX_DEPTH,
	parameter int LINE_MAX = ULAT_LINE_MAX
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int HW  = $clog2(TX_DEPTH);
	localparam int LW  = $clog2(LINE_MAX);
	localparam int FW  = $clog2(LINE_MAX + 1);
	localparam int CW  = (HW + 1 > 8) ? HW + 1 : 8;

	localparam logic [HW:0]   DEPTH_W  = (HW + 1)'(TX_DEPTH);
	localparam logic [HW-1:0] TX_LAST  = HW'(TX_DEPTH - 1);
	localparam logic [LW-1:0] LN_LAST  = LW'(LINE_MAX - 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(LINE_MAX);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EMIT,
		S_TX_POP,
		S_LN_POP
	} state_t;

	state_t          state_q;
	logic [HW-1:0]   head_q, tail_q;
	logic            accepted_q;
	logic [7:0]      remaining_q;
	logic [LW-1:0]   line_idx_q;
	logic [FW-1:0]   line_fill_q;
	logic [LW-1:0]   ln_ptr_q;
	res_t            pend_q;
	res_t            res_q;
	logic            res_valid_q;

	logic [7:0]      ring_mem [TX_DEPTH];
	logic [7:0]      line_mem [LINE_MAX];
	logic [7:0]      ring_rd_q;
	logic [7:0]      line_rd_q;

	logic            take;
	logic            slot_free;
	logic            is_term;
	logic [HW:0]     free_w;
	logic [HW-1:0]   head_nx, tail_nx;
	logic [LW-1:0]   idx_nx;
	logic            ln_last;

	logic            ring_we, ring_re;
	logic            line_we, line_re;
	logic [LW-1:0]   line_raddr;
	logic            tx_admit, tx_reject, tx_cont, tx_pop;
	logic            ln_start;
	logic            imm_res;
	res_t            imm_val;
	logic            res_load;
	res_t            res_d;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign take      = req_valid && req_ready;
	assign slot_free = !res_valid_q || res_ready;
	assign is_term   = (req.data_byte == CH_LF) || (req.data_byte == CH_CR);
	assign head_nx   = (head_q == TX_LAST) ? '0 : head_q + 1'b1;
	assign tail_nx   = (tail_q == TX_LAST) ? '0 : tail_q + 1'b1;
	assign idx_nx    = (line_idx_q == LN_LAST) ? '0 : line_idx_q + 1'b1;
	assign ln_last   = (FW'(ln_ptr_q) + FW'(1)) == line_fill_q;

	always_comb begin
		if (tail_q > head_q) begin
			free_w = {1'b0, tail_q} - {1'b0, head_q} - 1'b1;
		end else begin
			free_w = {1'b0, tail_q} + DEPTH_W - {1'b0, head_q} - 1'b1;
		end
	end

	always_comb begin
		ring_we    = 1'b0;
		ring_re    = 1'b0;
		line_we    = 1'b0;
		line_re    = 1'b0;
		line_raddr = '0;
		tx_admit   = 1'b0;
		tx_reject  = 1'b0;
		tx_cont    = 1'b0;
		tx_pop     = 1'b0;
		ln_start   = 1'b0;
		imm_res    = 1'b0;
		imm_val    = '{result_kind: KIND_STATUS, push_status: ST_ACCEPTED,
			out_byte: 8'd0, last_of_line: 1'b0};
		res_load   = 1'b0;
		res_d      = imm_val;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (req.opcode)
						OP_RX_BYTE: begin
							if (is_term) begin
								if (line_fill_q != '0) begin
									ln_start = 1'b1;
									line_re  = 1'b1;
								end
							end else begin
								line_we = 1'b1;
							end
						end
						OP_TX_READY: begin
							if (head_q != tail_q) begin
								tx_pop  = 1'b1;
								ring_re = 1'b1;
							end else begin
								imm_res = 1'b1;
								imm_val.result_kind = KIND_TX_IDLE;
							end
						end
						OP_TX_BYTE: begin
							if (req.first_of_message) begin
								imm_res = 1'b1;
								if (req.message_length == 8'd0) begin
									tx_reject = 1'b1;
									imm_val.push_status = ST_BAD_LEN;
								end else if (CW'(req.message_length) > CW'(free_w)) begin
									tx_reject = 1'b1;
									imm_val.push_status = ST_NO_ROOM;
								end else begin
									tx_admit = 1'b1;
									ring_we  = 1'b1;
								end
							end else if (accepted_q && remaining_q != 8'd0) begin
								tx_cont = 1'b1;
								ring_we = 1'b1;
							end
						end
						default: ;
					endcase
					if (imm_res && slot_free) begin
						res_load = 1'b1;
						res_d    = imm_val;
					end
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					res_load = 1'b1;
					res_d    = pend_q;
				end
			end
			S_TX_POP: begin
				if (slot_free) begin
					res_load = 1'b1;
					res_d    = '{result_kind: KIND_TX_BYTE, push_status: ST_ACCEPTED,
						out_byte: ring_rd_q, last_of_line: 1'b0};
				end
			end
			S_LN_POP: begin
				if (slot_free) begin
					res_load = 1'b1;
					res_d    = '{result_kind: KIND_LINE, push_status: ST_ACCEPTED,
						out_byte: line_rd_q, last_of_line: ln_last};
					if (!ln_last) begin
						line_re    = 1'b1;
						line_raddr = ln_ptr_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// ring memory: one write or one read per request
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[head_q] <= req.data_byte;
		end
		if (ring_re) begin
			ring_rd_q <= ring_mem[tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_idx_q] <= req.data_byte;
		end
		if (line_re) begin
			line_rd_q <= line_mem[line_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			accepted_q  <= 1'b0;
			remaining_q <= 8'd0;
			line_idx_q  <= '0;
			line_fill_q <= '0;
			ln_ptr_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			if (ring_we) begin
				head_q <= head_nx;
			end
			if (tx_admit) begin
				remaining_q <= req.message_length - 8'd1;
				accepted_q  <= (req.message_length != 8'd1);
			end else if (tx_reject) begin
				remaining_q <= 8'd0;
				accepted_q  <= 1'b0;
			end else if (tx_cont) begin
				remaining_q <= remaining_q - 8'd1;
				accepted_q  <= (remaining_q != 8'd1);
			end
			if (tx_pop) begin
				tail_q <= tail_nx;
			end
			if (line_we) begin
				line_idx_q <= idx_nx;
				if (line_fill_q != FILL_MAX) begin
					line_fill_q <= line_fill_q + 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (imm_res && !slot_free) begin
						pend_q  <= imm_val;
						state_q <= S_EMIT;
					end else if (tx_pop) begin
						state_q <= S_TX_POP;
					end else if (ln_start) begin
						ln_ptr_q <= '0;
						state_q  <= S_LN_POP;
					end
				end
				S_EMIT, S_TX_POP: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				S_LN_POP: begin
					if (res_load) begin
						if (ln_last) begin
							line_idx_q  <= '0;
							line_fill_q <= '0;
							state_q     <= S_IDLE;
						end else begin
							ln_ptr_q <= ln_ptr_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a write never fills the ring to the point where head meets tail
	a_ring_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |-> (head_nx != tail_q))
		else $error("ring write overran the tail");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_fill_q <= FILL_MAX)
		else $error("line fill beyond store size");

	a_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accepted_q |-> (remaining_q != 8'd0))
		else $error("message open with no bytes outstanding");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_valid_q || res_ready))
		else $error("result register overwritten while held");

	a_emit_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LN_POP) |-> (FW'(ln_ptr_q) < line_fill_q))
		else $error("line emission pointer past fill");

endmodule
